// ===== src/command_response_tracker_defines.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef COMMAND_RESPONSE_TRACKER_DEFINES_SVH
`define COMMAND_RESPONSE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define CRT_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRT_ASSERT(name, prop, msg) \
  `CRT_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define CRT_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define CRT_ASSERT(name, prop, msg)
`endif

`endif

// ===== src/crt_pkg.sv =====
`default_nettype none
package crt_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_QUESTION = 8'h3F;  // '?'
  localparam logic [7:0] CH_DOLLAR   = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH     = 8'h23;  // '#'
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;  // '\n'
  localparam logic [7:0] CH_UP_G     = 8'h47;  // 'G'
  localparam logic [7:0] CH_UP_I     = 8'h49;  // 'I'
  localparam logic [7:0] CH_UP_N     = 8'h4E;  // 'N'
  localparam logic [7:0] CH_UP_C     = 8'h43;  // 'C'
  localparam logic [7:0] CH_LO_O     = 8'h6F;  // 'o'
  localparam logic [7:0] CH_LO_K     = 8'h6B;  // 'k'
  localparam logic [7:0] CH_LO_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_LO_R     = 8'h72;  // 'r'

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_REPLY   = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic       is_local;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [7:0] third_char;
    logic [7:0] fourth_char;
  } crt_item_t;

  typedef struct packed {
    logic cmd_accepted;
    logic queue_overflow;
    logic line_is_local;
    logic line_valid;
  } crt_result_t;

  typedef struct packed {
    logic rsp_expected;
    logic is_local;
  } crt_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    crt_entry_t entry;
  } crt_queue_op_t;

  typedef struct packed {
    crt_entry_t head;
    logic       empty;
    logic       full;
  } crt_queue_stat_t;

endpackage
`default_nettype wire

// ===== src/crt_req_if.sv =====
`default_nettype none
interface crt_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       is_local;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic [7:0] third_char;
  logic [7:0] fourth_char;

  modport source (
    output valid, req_type, is_local, first_char, second_char, third_char, fourth_char,
    input  ready
  );
  modport sink (
    input  valid, req_type, is_local, first_char, second_char, third_char, fourth_char,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/crt_rsp_if.sv =====
`default_nettype none
interface crt_rsp_if;
  logic valid;
  logic ready;
  logic cmd_accepted;
  logic queue_overflow;
  logic line_is_local;
  logic line_valid;

  modport source (
    output valid, cmd_accepted, queue_overflow, line_is_local, line_valid,
    input  ready
  );
  modport sink (
    input  valid, cmd_accepted, queue_overflow, line_is_local, line_valid,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/command_response_tracker.sv =====
`default_nettype none
// Command/response tracker: each transaction on req_i is either a command sent to the
// controller (queued with its origin and a response-expected flag, dropped and flagged
// when the 16-entry queue is full, ignored when its first character is NUL) or a reply
// line (matched to the oldest queued command), and yields exactly one result transaction
// on rsp_o. An item is registered on entry, resolved against the queue head and the
// response state, and its result is held in an output register; a new item is taken
// every cycle while rsp_o is ready, so the throughput is then one item per cycle.
module command_response_tracker
  import crt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  crt_req_if.sink     req_i,
  crt_rsp_if.source   rsp_o
);

  logic            in_valid_q;
  crt_item_t       in_item_q;
  logic            out_valid_q;
  crt_result_t     out_res_q;
  logic            step;
  crt_result_t     result;
  crt_queue_op_t   q_op;
  crt_queue_stat_t q_stat;

  // advance the input register whenever the result register is free or drains
  assign step        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_item_q.req_type    <= req_i.req_type;
      in_item_q.is_local    <= req_i.is_local;
      in_item_q.first_char  <= req_i.first_char;
      in_item_q.second_char <= req_i.second_char;
      in_item_q.third_char  <= req_i.third_char;
      in_item_q.fourth_char <= req_i.fourth_char;
    end
    if (step) begin
      out_res_q <= result;
    end
  end

  crt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .stat_i   (q_stat),
    .op_o     (q_op),
    .result_o (result)
  );

  crt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (q_op),
    .stat_o (q_stat)
  );

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cmd_accepted   = out_res_q.cmd_accepted;
  assign rsp_o.queue_overflow = out_res_q.queue_overflow;
  assign rsp_o.line_is_local  = out_res_q.line_is_local;
  assign rsp_o.line_valid     = out_res_q.line_valid;

endmodule
`default_nettype wire

// ===== src/crt_queue.sv =====
`default_nettype none
`include "command_response_tracker_defines.svh"
module crt_queue
  import crt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crt_queue_op_t   op_i,
  output crt_queue_stat_t      stat_o
);

  crt_entry_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    count_d = count_q;
    if (op_i.push) begin
      wptr_d  = wrap_inc(wptr_q);
      count_d = count_q + 1'b1;
    end
    if (op_i.pop) begin
      rptr_d  = wrap_inc(rptr_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      entries_q[wptr_q] <= op_i.entry;
    end
  end

  assign stat_o.head  = entries_q[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

  `CRT_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH),
              "queue count above depth")
  `CRT_ASSERT(a_ptr_match, (rptr_q == wptr_q) == (stat_o.empty || stat_o.full),
              "pointers disagree with count")
  `CRT_ASSERT(a_push_count, op_i.push && !op_i.pop |=> count_q == $past(count_q) + 1'b1,
              "push did not grow the queue")

endmodule
`default_nettype wire

// ===== src/crt_ctrl.sv =====
`default_nettype none
`include "command_response_tracker_defines.svh"
module crt_ctrl
  import crt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire crt_item_t       item_i,
  input  wire crt_queue_stat_t stat_i,
  output crt_queue_op_t        op_o,
  output crt_result_t          result_o
);

  logic in_resp_q, in_resp_d;
  logic wants_rsp, is_ack, banner;

  always_comb begin
    wants_rsp = (item_i.first_char == CH_QUESTION) ||
                ((item_i.first_char == CH_DOLLAR) &&
                 ((item_i.second_char == CH_NEWLINE) || (item_i.second_char == CH_DOLLAR) ||
                  (item_i.second_char == CH_HASH)    || (item_i.second_char == CH_UP_G)    ||
                  (item_i.second_char == CH_UP_I)    || (item_i.second_char == CH_UP_N)    ||
                  (item_i.second_char == CH_UP_C)));
    is_ack = ((item_i.first_char == CH_LO_O) && (item_i.second_char == CH_LO_K)) ||
             ((item_i.first_char == CH_LO_E) && (item_i.second_char == CH_LO_R));
    banner = (item_i.third_char == CH_UP_G) && (item_i.fourth_char == CH_LO_R);
  end

  always_comb begin
    op_o.push               = 1'b0;
    op_o.pop                = 1'b0;
    op_o.entry.rsp_expected = wants_rsp;
    op_o.entry.is_local     = item_i.is_local;
    result_o                = '0;
    in_resp_d               = in_resp_q;
    if (item_i.req_type == REQ_COMMAND) begin
      if (item_i.first_char != CH_NUL) begin
        if (stat_i.full) begin
          result_o.queue_overflow = 1'b1;
        end else begin
          op_o.push             = step_i;
          result_o.cmd_accepted = 1'b1;
        end
      end
    end else if (!stat_i.empty) begin
      result_o.line_is_local = stat_i.head.is_local;
      if (!in_resp_q) begin
        if (is_ack && !stat_i.head.rsp_expected) begin
          op_o.pop = step_i;
        end else begin
          in_resp_d           = 1'b1;
          result_o.line_valid = 1'b1;
        end
      end else begin
        if (is_ack) begin
          op_o.pop  = step_i;
          in_resp_d = 1'b0;
        end else begin
          result_o.line_valid = 1'b1;
        end
      end
    end else begin
      // no command outstanding: only the startup banner passes to the host
      result_o.line_valid    = banner;
      result_o.line_is_local = !banner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_resp_q <= 1'b0;
    end else if (step_i) begin
      in_resp_q <= in_resp_d;
    end
  end

  `CRT_ASSERT(a_no_pop_empty, op_o.pop |-> !stat_i.empty, "pop from empty queue")
  `CRT_ASSERT(a_no_push_full, op_o.push |-> !stat_i.full, "push into full queue")
  `CRT_ASSERT(a_resp_exit, $fell(in_resp_q) |-> $past(op_o.pop),
              "response state left without acknowledgment")

endmodule
`default_nettype wire

// ===== tb/command_response_tracker_tb.sv =====
`default_nettype none
module command_response_tracker_tb;
  import crt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_RANDOM = 2000;

  localparam crt_result_t RES_NONE     = 4'b0000;
  localparam crt_result_t RES_ACCEPTED = 4'b1000;
  localparam crt_result_t RES_OVERFLOW = 4'b0100;
  localparam crt_result_t RES_IGNORED  = 4'b0010;
  localparam crt_result_t RES_BANNER   = 4'b0001;

  // second characters that make a '$' command expect a response
  localparam logic [7:0] DOLLAR_SUFFIX [7] = '{
    CH_NEWLINE, CH_DOLLAR, CH_HASH, CH_UP_G, CH_UP_I, CH_UP_N, CH_UP_C
  };

  typedef struct {
    crt_item_t   item;
    bit          has_golden;
    crt_result_t golden;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  crt_req_if req_bus ();
  crt_rsp_if rsp_bus ();

  command_response_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // shadow of the tracker's command queue and response state
  crt_entry_t        shadow_entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] shadow_rd;
  logic [QPTR_W-1:0] shadow_wr;
  int                shadow_count;
  bit                shadow_in_rsp;

  crt_result_t outcome_q [$];
  stim_row_t   stim_rows [$];
  int          error_count;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic got, input logic exp);
    if (got !== exp) begin
      report_error($sformatf("%s got %b, expected %b", name, got, exp));
    end
  endtask

  function automatic bit wants_response(input logic [7:0] c0, input logic [7:0] c1);
    if (c0 == CH_QUESTION) return 1'b1;
    if (c0 != CH_DOLLAR) return 1'b0;
    foreach (DOLLAR_SUFFIX[i]) begin
      if (c1 == DOLLAR_SUFFIX[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [QPTR_W-1:0] shadow_advance(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic crt_result_t track_transaction(input crt_item_t it);
    crt_result_t res;
    crt_entry_t  head;
    bit          ack;
    bit          pop;
    res = RES_NONE;
    pop = 1'b0;
    ack = (it.first_char == CH_LO_O && it.second_char == CH_LO_K) ||
          (it.first_char == CH_LO_E && it.second_char == CH_LO_R);
    if (it.req_type == REQ_COMMAND) begin
      if (it.first_char != CH_NUL) begin
        if (shadow_count >= int'(QUEUE_DEPTH)) begin
          res.queue_overflow = 1'b1;
        end else begin
          shadow_entries[shadow_wr].is_local     = it.is_local;
          shadow_entries[shadow_wr].rsp_expected = wants_response(it.first_char,
                                                                  it.second_char);
          shadow_wr = shadow_advance(shadow_wr);
          shadow_count++;
          res.cmd_accepted = 1'b1;
        end
      end
    end else if (shadow_count > 0) begin
      head = shadow_entries[shadow_rd];
      res.line_is_local = head.is_local;
      if (!shadow_in_rsp) begin
        if (ack && !head.rsp_expected) begin
          pop = 1'b1;
        end else begin
          shadow_in_rsp  = 1'b1;
          res.line_valid = 1'b1;
        end
      end else if (ack) begin
        pop = 1'b1;
        shadow_in_rsp = 1'b0;
      end else begin
        res.line_valid = 1'b1;
      end
      if (pop) begin
        shadow_rd = shadow_advance(shadow_rd);
        shadow_count--;
      end
    end else if (it.third_char == CH_UP_G && it.fourth_char == CH_LO_R) begin
      res.line_valid = 1'b1;
    end else begin
      res.line_is_local = 1'b1;
    end
    return res;
  endfunction

  task automatic add_row(input logic rt, input logic loc,
                         input logic [7:0] c0, input logic [7:0] c1,
                         input logic [7:0] c2, input logic [7:0] c3,
                         input bit has, input crt_result_t gold);
    stim_row_t row;
    row.item       = '{rt, loc, c0, c1, c2, c3};
    row.has_golden = has;
    row.golden     = gold;
    stim_rows.push_back(row);
  endtask

  // hold the item on the bus until the tracker takes it, then record its outcome
  task automatic send_item(input crt_item_t it, input bit has, input crt_result_t gold);
    crt_result_t predicted;
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= it.req_type;
    req_bus.is_local    <= it.is_local;
    req_bus.first_char  <= it.first_char;
    req_bus.second_char <= it.second_char;
    req_bus.third_char  <= it.third_char;
    req_bus.fourth_char <= it.fourth_char;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = track_transaction(it);
    outcome_q.push_back(has ? gold : predicted);
  endtask

  // end a burst with a random gap; some bursts run back to back
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  function automatic crt_item_t random_item(input int cmd_pct);
    crt_item_t it;
    int        sel;
    it.req_type    = ($urandom_range(99) < cmd_pct) ? REQ_COMMAND : REQ_REPLY;
    it.is_local    = 1'($urandom_range(1));
    it.first_char  = 8'($urandom_range(255));
    it.second_char = 8'($urandom_range(255));
    it.third_char  = 8'($urandom_range(255));
    it.fourth_char = 8'($urandom_range(255));
    sel = $urandom_range(9);
    if (it.req_type == REQ_COMMAND) begin
      if (sel < 3) begin
        it.first_char = CH_QUESTION;
      end else if (sel < 6) begin
        it.first_char = CH_DOLLAR;
        if (sel < 5) it.second_char = DOLLAR_SUFFIX[3'($urandom_range(6))];
      end else if (sel == 6) begin
        it.first_char = CH_NUL;
      end
    end else begin
      if (sel < 4) begin
        if ($urandom_range(1)) begin
          it.first_char  = CH_LO_O;
          it.second_char = CH_LO_K;
        end else begin
          it.first_char  = CH_LO_E;
          it.second_char = CH_LO_R;
        end
      end else if (sel == 4) begin
        it.third_char  = CH_UP_G;
        it.fourth_char = CH_LO_R;
      end else if (sel == 5) begin
        // near miss of an acknowledgment
        it.first_char = $urandom_range(1) ? CH_LO_O : CH_LO_E;
      end
    end
    return it;
  endfunction

  // receiver stall pattern: the mode follows bits [9:8] of a free-running cycle counter
  int unsigned rsp_cycle;
  always @(posedge clk_i) begin
    rsp_cycle <= rsp_cycle + 1;
    case (rsp_cycle[9:8])
      2'd0:    rsp_bus.ready <= 1'b1;
      2'd1:    rsp_bus.ready <= ($urandom_range(3) != 0);
      2'd2:    rsp_bus.ready <= (rsp_cycle[1:0] == 2'd0);
      default: rsp_bus.ready <= ($urandom_range(9) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    crt_result_t exp;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (outcome_q.size() == 0) begin
        report_error($sformatf("unexpected result %b%b%b%b", rsp_bus.cmd_accepted,
                               rsp_bus.queue_overflow, rsp_bus.line_is_local,
                               rsp_bus.line_valid));
      end else begin
        exp = outcome_q.pop_front();
        check_field("cmd_accepted", rsp_bus.cmd_accepted, exp.cmd_accepted);
        check_field("queue_overflow", rsp_bus.queue_overflow, exp.queue_overflow);
        check_field("line_is_local", rsp_bus.line_is_local, exp.line_is_local);
        check_field("line_valid", rsp_bus.line_valid, exp.line_valid);
      end
    end
  end

  initial begin
    int cmd_pct;
    rst_ni              <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_COMMAND;
    req_bus.is_local    <= 1'b0;
    req_bus.first_char  <= CH_NUL;
    req_bus.second_char <= CH_NUL;
    req_bus.third_char  <= CH_NUL;
    req_bus.fourth_char <= CH_NUL;
    error_count         = 0;
    burst_left          = 0;
    shadow_rd           = '0;
    shadow_wr           = '0;
    shadow_count        = 0;
    shadow_in_rsp       = 1'b0;

    // empty queue: ignored line, startup banner, empty command
    add_row(REQ_REPLY,   1'b0, CH_LO_O, CH_LO_K, 8'h00, 8'h00, 1, RES_IGNORED);
    add_row(REQ_REPLY,   1'b1, 8'hFF, 8'hFF, CH_UP_G, CH_LO_R, 1, RES_BANNER);
    add_row(REQ_COMMAND, 1'b1, CH_NUL, 8'hFF, 8'hFF, 8'hFF, 1, RES_NONE);
    // every response-expected decode plus plain commands, up to a full queue
    add_row(REQ_COMMAND, 1'b1, CH_QUESTION, 8'h00, 8'h00, 8'h00, 1, RES_ACCEPTED);
    add_row(REQ_COMMAND, 1'b0, CH_DOLLAR, CH_NEWLINE, 8'h00, 8'h00, 1, RES_ACCEPTED);
    add_row(REQ_COMMAND, 1'b1, CH_DOLLAR, CH_DOLLAR, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_DOLLAR, CH_HASH, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, CH_DOLLAR, CH_UP_G, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_DOLLAR, CH_UP_I, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, CH_DOLLAR, CH_UP_N, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_DOLLAR, CH_UP_C, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, CH_DOLLAR, 8'h48, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_UP_G, 8'h30, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, RES_ACCEPTED);
    add_row(REQ_COMMAND, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 1, RES_ACCEPTED);
    add_row(REQ_COMMAND, 1'b1, CH_LO_O, CH_LO_K, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_QUESTION, CH_QUESTION, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, 8'h80, 8'h7F, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b0, CH_DOLLAR, 8'h00, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_COMMAND, 1'b1, CH_QUESTION, 8'h00, 8'h00, 8'h00, 1, RES_OVERFLOW);
    // drain: acknowledgment opening a response, content, closing acknowledgment
    add_row(REQ_REPLY,   1'b0, CH_LO_O, CH_LO_K, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_REPLY,   1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, RES_NONE);
    add_row(REQ_REPLY,   1'b1, CH_LO_E, CH_LO_R, 8'h00, 8'h00, 0, RES_NONE);
    add_row(REQ_REPLY,   1'b0, 8'h00, 8'h00, CH_UP_G, CH_LO_R, 0, RES_NONE);
    add_row(REQ_REPLY,   1'b1, CH_LO_O, CH_LO_K, 8'h00, 8'h00, 0, RES_NONE);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      send_item(stim_rows[i].item, stim_rows[i].has_golden, stim_rows[i].golden);
      pace_sender();
    end

    cmd_pct = 50;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // shift the command/reply mix so the queue both fills up and runs dry
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0:       cmd_pct = 25;
          1:       cmd_pct = 50;
          default: cmd_pct = 75;
        endcase
      end
      send_item(random_item(cmd_pct), 1'b0, RES_NONE);
      pace_sender();
    end
    req_bus.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
